// ===== rtl/jse_pkg.sv =====
// Package with the shared types and character constants of the JSON string escaper.
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned POS_W       = $clog2(MAX_RESULTS);
    localparam int unsigned LEN_W       = POS_W + 1;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W  = FIFO_PTR_W + 1;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PAIR,
        ESC_UNI
    } esc_kind_t;

    typedef struct packed {
        logic              string_start;
        logic              string_end;
        logic              byte_present;
        esc_kind_t         kind;
        logic [7:0]        data;
        logic [POS_W-1:0]  len_m1;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/jse_in_if.sv =====
// Input channel interface: one string byte word with its framing flags.
`timescale 1ns / 1ps
`default_nettype none

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       string_start;
    logic       string_end;

    modport source (output valid, output text_byte, output byte_present,
                    output string_start, output string_end, input ready);
    modport sink   (input valid, input text_byte, input byte_present,
                    input string_start, input string_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/jse_out_if.sv =====
// Output channel interface: one escaped output byte word with its markers.
`timescale 1ns / 1ps
`default_nettype none

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;

    modport source (output valid, output out_byte, output run_last,
                    output string_done, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input string_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/jse_front.sv =====
// Front end: accepts input words, classifies the byte and builds an emit job.
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
    jse_in_if.sink          text,
    input  wire logic       full,
    output jse_pkg::job_t   job,
    output logic            push
);

    jse_pkg::esc_kind_t           kind;
    logic [7:0]                   data;
    logic [jse_pkg::LEN_W-1:0]    body_len;
    logic [jse_pkg::LEN_W-1:0]    total_len;

    always_comb
    begin
        kind = jse_pkg::ESC_NONE;
        data = text.text_byte;
        if (text.text_byte < jse_pkg::CTRL_LIMIT)
        begin
            unique case (text.text_byte)
                jse_pkg::CHAR_LF:
                begin
                    kind = jse_pkg::ESC_PAIR;
                    data = jse_pkg::CHAR_N;
                end
                jse_pkg::CHAR_CR:
                begin
                    kind = jse_pkg::ESC_PAIR;
                    data = jse_pkg::CHAR_R;
                end
                jse_pkg::CHAR_TAB:
                begin
                    kind = jse_pkg::ESC_PAIR;
                    data = jse_pkg::CHAR_T;
                end
                default:
                begin
                    kind = jse_pkg::ESC_UNI;
                end
            endcase
        end
        else
        begin
            unique case (text.text_byte)
                jse_pkg::CHAR_QUOTE, jse_pkg::CHAR_BSLASH:
                begin
                    kind = jse_pkg::ESC_PAIR;
                end
                default:
                begin
                    kind = jse_pkg::ESC_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (!text.byte_present)
        begin
            body_len = '0;
        end
        else
        begin
            unique case (kind)
                jse_pkg::ESC_PAIR: body_len = jse_pkg::LEN_W'(2);
                jse_pkg::ESC_UNI:  body_len = jse_pkg::LEN_W'(6);
                default:           body_len = jse_pkg::LEN_W'(1);
            endcase
        end
        total_len = body_len
                  + jse_pkg::LEN_W'(text.string_start)
                  + jse_pkg::LEN_W'(text.string_end);
    end

    always_comb
    begin
        job.string_start = text.string_start;
        job.string_end   = text.string_end;
        job.byte_present = text.byte_present;
        job.kind         = kind;
        job.data         = data;
        job.len_m1       = jse_pkg::POS_W'(total_len - jse_pkg::LEN_W'(1));
    end

    // drop words that produce no output
    assign text.ready = !full;
    assign push       = text.valid && !full && (total_len != '0);

endmodule

`default_nettype wire

// ===== rtl/jse_fifo.sv =====
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module jse_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire jse_pkg::job_t  push_job,
    input  wire logic           pop,
    output jse_pkg::job_t       head_job,
    output logic                not_empty,
    output logic                full
);

    jse_pkg::job_t                     entry_reg [jse_pkg::FIFO_DEPTH];
    logic [jse_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [jse_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [jse_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [jse_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [jse_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [jse_pkg::FIFO_CNT_W-1:0]    count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == jse_pkg::FIFO_CNT_W'(jse_pkg::FIFO_DEPTH));
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + jse_pkg::FIFO_CNT_W'(push)
                    - jse_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("job queue popped while empty");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("job queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/jse_back.sv =====
// Back end: walks each job byte by byte into a registered output stage.
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire jse_pkg::job_t  head_job,
    input  wire logic           not_empty,
    output logic                pop,
    jse_out_if.source           escaped
);

    logic [jse_pkg::POS_W-1:0]  pos_reg;
    logic [jse_pkg::POS_W-1:0]  pos_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [7:0]                 byte_reg;
    logic                       last_reg;
    logic                       done_reg;

    logic                       load;
    logic                       is_last;
    logic [jse_pkg::POS_W-1:0]  body_pos;
    logic [7:0]                 body_byte;
    logic [7:0]                 cur_byte;
    logic                       cur_done;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return jse_pkg::CHAR_ZERO + {4'h0, v};
        end
        return jse_pkg::CHAR_LOW_A + {4'h0, v} - 8'd10;
    endfunction

    always_comb
    begin
        body_pos = pos_reg - jse_pkg::POS_W'(head_job.string_start);
        unique case (head_job.kind)
            jse_pkg::ESC_PAIR:
            begin
                body_byte = (body_pos == '0) ? jse_pkg::CHAR_BSLASH : head_job.data;
            end
            jse_pkg::ESC_UNI:
            begin
                case (body_pos)
                    jse_pkg::POS_W'(0): body_byte = jse_pkg::CHAR_BSLASH;
                    jse_pkg::POS_W'(1): body_byte = jse_pkg::CHAR_U;
                    jse_pkg::POS_W'(4): body_byte = hex_char(head_job.data[7:4]);
                    jse_pkg::POS_W'(5): body_byte = hex_char(head_job.data[3:0]);
                    default:            body_byte = jse_pkg::CHAR_ZERO;
                endcase
            end
            default:
            begin
                body_byte = head_job.data;
            end
        endcase
    end

    always_comb
    begin
        is_last  = (pos_reg == head_job.len_m1);
        cur_done = 1'b0;
        if (head_job.string_start && (pos_reg == '0))
        begin
            cur_byte = jse_pkg::CHAR_QUOTE;
        end
        else if (head_job.string_end && is_last)
        begin
            cur_byte = jse_pkg::CHAR_QUOTE;
            cur_done = 1'b1;
        end
        else
        begin
            cur_byte = body_byte;
        end
    end

    always_comb
    begin
        load       = not_empty && (!valid_reg || escaped.ready);
        pop        = load && is_last;
        valid_next = load || (valid_reg && !escaped.ready);
        pos_next   = pos_reg;
        if (load)
        begin
            pos_next = is_last ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
            done_reg <= cur_done;
        end
    end

    assign escaped.valid       = valid_reg;
    assign escaped.out_byte    = byte_reg;
    assign escaped.run_last    = last_reg;
    assign escaped.string_done = done_reg;

    a_pos_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        not_empty |-> (pos_reg <= head_job.len_m1))
        else $error("byte position beyond job length");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg) |-> last_reg)
        else $error("closing quote not marked as last byte of its word");

    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pos_reg == '0))
        else $error("byte position not cleared after job completes");

endmodule

`default_nettype wire

// ===== rtl/json_string_escaper.sv =====
// Top level of the JSON string escaper: front end, job queue and byte sequencer.
//
// Usage: string bytes enter on the text channel, one word each, with
// string_start on the first word and string_end on the last of a string;
// a word with byte_present low carries no byte (empty string framing).
// The escaped, quoted text leaves on the escaped channel, one byte a word.
// run_last marks the last output byte of an input word, string_done marks
// a closing quote. A word with no byte, no start and no end yields nothing.
// With the queue empty, the first output byte of a word passes through
// the job queue register, then the output register, before it is valid.
// Throughput: one output byte per cycle while the receiver is ready; a word
// yields up to 8 output bytes, set by the byte sequencer; plain bytes go
// at one word per cycle. A four-entry job queue lets the input keep flowing
// while the sequencer expands an escape; the input stalls only when the
// queue fills. When the receiver stalls, the output register holds its
// byte and the queue absorbs input until full. Reset empties the queue,
// clears the sequencer's byte position and clears the output valid.
`timescale 1ns / 1ps
`default_nettype none

module json_string_escaper (
    input  wire logic   clk,
    input  wire logic   rst_n,
    jse_in_if.sink      text,
    jse_out_if.source   escaped
);

    jse_pkg::job_t  front_job;
    jse_pkg::job_t  head_job;
    logic           push;
    logic           pop;
    logic           full;
    logic           not_empty;

    jse_front u_front (
        .text (text),
        .full (full),
        .job  (front_job),
        .push (push)
    );

    jse_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty),
        .full      (full)
    );

    jse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .not_empty (not_empty),
        .pop       (pop),
        .escaped   (escaped)
    );

endmodule

`default_nettype wire
